>>> hdl/mce_pkg.sv
// shared types and constants of the multicorn escape-time block
// beat structs, register file layout, sequencer states; no dependencies

package mce_pkg;

  localparam int MCE_MAX_DEGREE = 16;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    CFG_C_RE        = 3'd0,
    CFG_C_IM        = 3'd1,
    CFG_DEGREE      = 3'd2,
    CFG_ESCAPE_NORM = 3'd3,
    CFG_MAX_ITER    = 3'd4
  } cfg_idx_t;

  localparam logic [4:0]  DEGREE_RESET      = 5'd3;
  localparam logic [30:0] ESCAPE_NORM_RESET = 31'd1677721600;
  localparam logic [15:0] MAX_ITER_RESET    = 16'd50;

  typedef struct packed {
    logic signed [31:0] c_re;
    logic signed [31:0] c_im;
    logic [4:0]         degree;
    logic [30:0]        escape_norm;
    logic [15:0]        max_iter;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] z_re;
    logic signed [31:0] z_im;
  } pt_beat_t;

  typedef struct packed {
    logic [15:0] escape_count;
    logic        bounded;
  } res_beat_t;

  // handshake group between the top level and the core
  typedef struct packed {
    logic busy;
    logic res_valid;
  } core_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAG,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } state_t;

endpackage

>>> hdl/mce_mul.sv
// shared 32x32 signed multiplier with registered product
// no dependencies beyond the clock

module mce_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> hdl/mce_core.sv
// iteration sequencer and datapath around the shared multiplier
// depends on mce_pkg and mce_mul

module mce_core import mce_pkg::*; #(
  parameter int MAX_DEGREE = MCE_MAX_DEGREE
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       start,
  input  pt_beat_t   pt,
  input  logic       res_take,
  output core_stat_t stat,
  output res_beat_t  res
);

  localparam int DW = $clog2(MAX_DEGREE + 1);

  state_t state, state_next;
  logic [2:0] st, st_next;

  logic signed [31:0] x_re, x_im, t_re, t_im, n_re;
  logic signed [39:0] p_hold;
  logic [62:0]        sq;
  logic [15:0]        i_cnt;
  logic [DW-1:0]      j_cnt, j_inc, d_eff;
  logic               sat;

  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod;
  logic signed [39:0] prod_q;
  logic [63:0]        mag_sum, limit;
  logic               cont;
  logic signed [40:0] sum_re, sum_im, upd_re, upd_im;

  function automatic logic ovf(input logic signed [40:0] v);
    return !((&v[40:31]) || (~|v[40:31]));
  endfunction

  function automatic logic signed [31:0] clip(input logic signed [40:0] v);
    if (ovf(v)) return v[40] ? 32'sh80000000 : 32'sh7fffffff;
    return v[31:0];
  endfunction

  mce_mul u_mul (
    .clk (clk),
    .a   (op_a),
    .b   (op_b),
    .p   (prod)
  );

  // degree zero acts as one, large degrees clamp
  always_comb begin
    if (cfg.degree == 5'd0) begin
      d_eff = DW'(1);
    end else if (32'(cfg.degree) > MAX_DEGREE) begin
      d_eff = DW'(MAX_DEGREE);
    end else begin
      d_eff = DW'(cfg.degree);
    end
  end

  assign prod_q  = prod[63:24];
  assign mag_sum = {1'b0, sq} + {1'b0, prod[62:0]};
  assign limit   = {9'd0, cfg.escape_norm, 24'd0};
  assign cont    = (i_cnt < cfg.max_iter) && !sat && (mag_sum < limit);
  assign j_inc   = j_cnt + 1'b1;
  assign sum_re  = {p_hold[39], p_hold} - {prod_q[39], prod_q};
  assign sum_im  = {p_hold[39], p_hold} + {prod_q[39], prod_q};
  assign upd_re  = {{9{t_re[31]}}, t_re} + {{9{cfg.c_re[31]}}, cfg.c_re};
  assign upd_im  = {{9{cfg.c_im[31]}}, cfg.c_im} - {{9{t_im[31]}}, t_im};

  // next state
  always_comb begin
    state_next = state;
    st_next    = st;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_MAG;
          st_next    = 3'd0;
        end
      end
      ST_MAG: begin
        if (st != 3'd2) begin
          st_next = st + 3'd1;
        end else begin
          st_next = 3'd0;
          if (!cont) begin
            state_next = ST_DONE;
          end else if (d_eff == DW'(1)) begin
            state_next = ST_UPD;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (st != 3'd4) begin
          st_next = st + 3'd1;
        end else begin
          st_next = 3'd0;
          if (j_inc == d_eff) state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        state_next = ST_MAG;
        st_next    = 3'd0;
      end
      ST_DONE: begin
        if (res_take) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and multiplier operand select
  always_comb begin
    stat.busy      = (state != ST_IDLE);
    stat.res_valid = (state == ST_DONE);
    res.escape_count = i_cnt;
    res.bounded      = (i_cnt >= cfg.max_iter);
    op_a = x_re;
    op_b = x_re;
    unique case (state)
      ST_MAG: begin
        if (st == 3'd1) begin
          op_a = x_im;
          op_b = x_im;
        end
      end
      ST_MUL: begin
        unique case (st)
          3'd0: begin op_a = t_re; op_b = x_re; end
          3'd1: begin op_a = t_im; op_b = x_im; end
          3'd2: begin op_a = t_re; op_b = x_im; end
          3'd3: begin op_a = t_im; op_b = x_re; end
          default: begin op_a = t_re; op_b = x_re; end
        endcase
      end
      default: begin
        op_a = x_re;
        op_b = x_re;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      st    <= 3'd0;
    end else begin
      state <= state_next;
      st    <= st_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          x_re  <= pt.z_re;
          x_im  <= pt.z_im;
          i_cnt <= 16'd0;
          sat   <= 1'b0;
        end
      end
      ST_MAG: begin
        if (st == 3'd1) sq <= prod[62:0];
        if (st == 3'd2) begin
          t_re  <= x_re;
          t_im  <= x_im;
          j_cnt <= DW'(1);
        end
      end
      ST_MUL: begin
        unique case (st)
          3'd1: p_hold <= prod_q;
          3'd2: begin
            n_re <= clip(sum_re);
            if (ovf(sum_re)) sat <= 1'b1;
          end
          3'd3: p_hold <= prod_q;
          3'd4: begin
            t_re  <= n_re;
            t_im  <= clip(sum_im);
            j_cnt <= j_inc;
            if (ovf(sum_im)) sat <= 1'b1;
          end
          default: ;
        endcase
      end
      ST_UPD: begin
        x_re  <= clip(upd_re);
        x_im  <= clip(upd_im);
        i_cnt <= i_cnt + 16'd1;
        if (ovf(upd_re) || ovf(upd_im)) sat <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/multicorn_escape_time.sv
// top level of the multicorn escape-time block: config registers, output register
// depends on mce_pkg, mce_core (which uses mce_mul)

// usage
// - pt channel (valid/stall): one start point z per beat, signed Q8.24
// - res channel (valid/stall): one escape count and bounded flag per beat
// - cfg channel (valid/ready): register index and data, ready is always high;
//   write only while no point is in flight
// - one iteration runs on the single shared multiplier: the squared norm,
//   then d-1 complex multiplies, then the update
// - after n iterations and a final norm check the result beat shows, and the
//   next point can be taken in the same cycle that the result beat shows
// - pt_stall is high after the accepted beat until the core is idle again;
//   a point is taken while the previous result still waits in the output register
// - res_stall holds the result register; a finished core then waits for it
// - reset clears control state and loads the register reset values
//   (c = 0, degree 3, escape norm 100.0, limit 50)

module multicorn_escape_time import mce_pkg::*; #(
  parameter int MAX_DEGREE = MCE_MAX_DEGREE
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       pt_valid,
  output logic       pt_stall,
  input  pt_beat_t   pt,
  output logic       res_valid,
  input  logic       res_stall,
  output res_beat_t  res,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t       cfg;
  core_stat_t stat;
  res_beat_t  core_res;
  logic       start, res_take;

  assign cfg_ready = 1'b1;
  assign pt_stall  = stat.busy;
  assign start     = pt_valid && !stat.busy;
  // result register frees up when empty or when its beat leaves
  assign res_take  = stat.res_valid && (!res_valid || !res_stall);

  // register file, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.c_re        <= 32'sd0;
      cfg.c_im        <= 32'sd0;
      cfg.degree      <= DEGREE_RESET;
      cfg.escape_norm <= ESCAPE_NORM_RESET;
      cfg.max_iter    <= MAX_ITER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_C_RE:        cfg.c_re        <= cfg_data;
        CFG_C_IM:        cfg.c_im        <= cfg_data;
        CFG_DEGREE:      cfg.degree      <= cfg_data[4:0];
        CFG_ESCAPE_NORM: cfg.escape_norm <= cfg_data[30:0];
        CFG_MAX_ITER:    cfg.max_iter    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  mce_core #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .start    (start),
    .pt       (pt),
    .res_take (res_take),
    .stat     (stat),
    .res      (core_res)
  );

  // output register, payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_take) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) res <= core_res;
  end

endmodule

>>> hdl/mce_checker.sv
// port-level checker for multicorn_escape_time, bound to the top level
// depends on mce_pkg

module mce_checker import mce_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      pt_valid,
  input logic      pt_stall,
  input logic      res_valid,
  input logic      res_stall,
  input res_beat_t res,
  input logic      cfg_valid,
  input logic      cfg_ready
);

  // a taken point keeps the core busy into the norm check
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    pt_valid && !pt_stall |=> pt_stall ##1 pt_stall)
    else $error("pt_stall dropped too soon after an accepted beat");

  // reset leaves the block idle and empty
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !pt_stall && !res_valid)
    else $error("block not idle after reset");

  // a stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result beat changed");

  // config writes are never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind multicorn_escape_time mce_checker u_mce_checker (
  .clk       (clk),
  .rst       (rst),
  .pt_valid  (pt_valid),
  .pt_stall  (pt_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
